### rtl/core/cgra_functional_unit_alu_assert.svh
// Assertion macros shared by the checker of the CGRA functional unit.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef CGRA_FUNCTIONAL_UNIT_ALU_ASSERT_SVH
`define CGRA_FUNCTIONAL_UNIT_ALU_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define CGRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cgra functional unit: implication check failed");

// Next-cycle implication, quiet while reset is asserted.
`define CGRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cgra functional unit: next-cycle check failed");

`endif

### rtl/core/cgra_fu_pkg.sv
// Shared types and constants of the CGRA functional unit.
// Used by the top level and its checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cgra_fu_pkg;

  // Sizes of the register file and immediate.
  localparam int REG_COUNT = 64;
  localparam int REG_AW    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int IMM_BITS  = 12;

  // Fixed field widths.
  localparam int OP_W     = 5;
  localparam int SEL_W    = 7;
  localparam int IMM_W    = 12;
  localparam int DATA_W   = 64;
  localparam int DEST_W   = 6;
  localparam int CYC_W    = 13;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 4;
  localparam int NBR_NUM  = 4;

  // Packed stream widths, rounded up to whole bytes.
  localparam int S_TDATA_W = 296;
  localparam int M_TDATA_W = 88;

  // Input field offsets within s_axis_tdata.
  localparam int OFS_OP  = 0;
  localparam int OFS_SA  = 5;
  localparam int OFS_SB  = 12;
  localparam int OFS_SC  = 19;
  localparam int OFS_IMM = 26;
  localparam int OFS_NBR = 38;

  // Mask applied to the immediate field.
  localparam logic [IMM_W-1:0] IMM_MASK = IMM_W'((64'd1 << IMM_BITS) - 64'd1);

  // Operand selector codes.
  localparam logic [SEL_W-1:0] SEL_SELF   = 7'd64;
  localparam logic [SEL_W-1:0] SEL_NBR1   = 7'd65;
  localparam logic [SEL_W-1:0] SEL_NBR4   = 7'd68;
  localparam logic [SEL_W-1:0] SEL_REG_LIM = SEL_W'(REG_COUNT);

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] CFG_MULT_EN = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_RF_EN   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_NBR     = 2'd2;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_NOP         = 5'd0,
    OP_ADD         = 5'd1,
    OP_SUB         = 5'd2,
    OP_ADDI        = 5'd3,
    OP_SUBI        = 5'd4,
    OP_MUL         = 5'd5,
    OP_SLL         = 5'd6,
    OP_SLLI        = 5'd7,
    OP_SRL         = 5'd8,
    OP_SRLI        = 5'd9,
    OP_SRLW        = 5'd10,
    OP_SRLWI       = 5'd11,
    OP_SRA         = 5'd12,
    OP_SRAI        = 5'd13,
    OP_SRAW        = 5'd14,
    OP_SRAWI       = 5'd15,
    OP_OR          = 5'd16,
    OP_ORI         = 5'd17,
    OP_AND         = 5'd18,
    OP_ANDI        = 5'd19,
    OP_XOR         = 5'd20,
    OP_XORI        = 5'd21,
    OP_CARRY       = 5'd22,
    OP_RECONF_IFEQ = 5'd23,
    OP_RECONF_IFNE = 5'd24
  } op_e;

endpackage

`default_nettype wire

### rtl/core/cgra_fu_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Self-contained; used for the register file of the CGRA functional unit.
`timescale 1ns / 1ps
`default_nettype none

module cgra_fu_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  wire logic [Width-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_b_i,
  output logic      [Width-1:0]                 rdata_a_o,
  output logic      [Width-1:0]                 rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports, read-before-write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/cgra_functional_unit_alu.sv
// Channel   Direction  Width  Contents
// s_axis    in         296    req_type, src_a, src_b, src_c, imm, nbr_one..nbr_four
// m_axis    out        88     out_value, reg_written, dest_index, reconf_hit,
//                             reconf_cycles, aborted
// cfg       in         2+4    write enable, register index, write data
//
// One request is taken every cycle unless a stalled result holds the ALU stage.
// The register file is read into the operand stage registers; the ALU then fills the result register.
// A result that writes a register is forwarded to the next request at once.
// Reset clears the register file through per-entry valid bits; no clearing pass.
// A stalled result holds the ALU stage, which in turn lowers s_axis_tready.
//
// Top level of the CGRA functional unit: operand stage, ALU and result register.
// Depends on cgra_fu_pkg and cgra_fu_ram.
`timescale 1ns / 1ps
`default_nettype none

module cgra_functional_unit_alu (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Configuration write port.
  input  wire logic                                  cfg_we_i,
  input  wire logic [cgra_fu_pkg::CFG_AW-1:0]        cfg_addr_i,
  input  wire logic [cgra_fu_pkg::CFG_DW-1:0]        cfg_wdata_i,
  // Request stream.
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // req_type[4:0], src_a[11:5], src_b[18:12], src_c[25:19], imm[37:26],
  // nbr_one[101:38], nbr_two[165:102], nbr_three[229:166], nbr_four[293:230]
  input  wire logic [cgra_fu_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // Result stream.
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // out_value[63:0], reg_written[64], dest_index[70:65], reconf_hit[71],
  // reconf_cycles[84:72], aborted[85]
  output logic      [cgra_fu_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

  localparam int AW = cgra_fu_pkg::REG_AW;
  localparam int DW = cgra_fu_pkg::DATA_W;
  localparam int SW = cgra_fu_pkg::SEL_W;

  // Configuration registers.
  logic                               mult_en_q;
  logic                               rf_en_q;
  logic [cgra_fu_pkg::NBR_NUM-1:0]    nbr_present_q;

  // Operand stage registers.
  logic                               s1_valid_q;
  logic [cgra_fu_pkg::OP_W-1:0]       s1_op_q;
  logic [SW-1:0]                      s1_sa_q;
  logic [SW-1:0]                      s1_sb_q;
  logic [SW-1:0]                      s1_sc_q;
  logic [cgra_fu_pkg::IMM_W-1:0]      s1_imm_q;
  logic [DW-1:0]                      s1_nbr_q [cgra_fu_pkg::NBR_NUM];
  logic                               s1_byp_a_q;
  logic                               s1_byp_2_q;
  logic                               s1_vld_a_q;
  logic                               s1_vld_2_q;

  // Unit state.
  logic [DW-1:0]                      hold_q;
  logic [cgra_fu_pkg::REG_COUNT-1:0]  rf_valid_q;

  // Result register.
  logic                               out_valid_q;
  logic [DW-1:0]                      out_value_q;
  logic                               out_wr_q;
  logic [cgra_fu_pkg::DEST_W-1:0]     out_dest_q;
  logic                               out_hit_q;
  logic [cgra_fu_pkg::CYC_W-1:0]      out_cycles_q;
  logic                               out_abort_q;

  // Handshake and request decode.
  logic                               accept;
  logic                               s1_advance;
  logic [cgra_fu_pkg::OP_W-1:0]       in_op;
  logic [SW-1:0]                      in_sa;
  logic [SW-1:0]                      in_sb;
  logic [SW-1:0]                      in_sc;
  logic [SW-1:0]                      in_sel2;
  logic                               in_reconf;

  // Register file read data.
  logic [DW-1:0]                      rf_rdata_a;
  logic [DW-1:0]                      rf_rdata_b;

  // ALU stage results.
  logic [DW-1:0]                      alu_r;
  logic                               alu_nop;
  logic                               alu_abort;
  logic                               alu_hit;
  logic                               alu_wr;
  logic [cgra_fu_pkg::CYC_W-1:0]      alu_cycles;

  // Request fields and second read address (B for reconf, C otherwise).
  assign in_op     = s_axis_tdata[cgra_fu_pkg::OFS_OP +: cgra_fu_pkg::OP_W];
  assign in_sa     = s_axis_tdata[cgra_fu_pkg::OFS_SA +: SW];
  assign in_sb     = s_axis_tdata[cgra_fu_pkg::OFS_SB +: SW];
  assign in_sc     = s_axis_tdata[cgra_fu_pkg::OFS_SC +: SW];
  assign in_reconf = (in_op == cgra_fu_pkg::OP_RECONF_IFEQ) ||
                     (in_op == cgra_fu_pkg::OP_RECONF_IFNE);
  assign in_sel2   = in_reconf ? in_sb : in_sc;

  // The ALU stage moves on when the result register is free or being emptied.
  assign s1_advance    = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_en_q     <= 1'b0;
      rf_en_q       <= 1'b0;
      nbr_present_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        cgra_fu_pkg::CFG_MULT_EN: mult_en_q     <= cfg_wdata_i[0];
        cgra_fu_pkg::CFG_RF_EN:   rf_en_q       <= cfg_wdata_i[0];
        cgra_fu_pkg::CFG_NBR:     nbr_present_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Register file storage.
  cgra_fu_ram #(
    .Width (DW),
    .Depth (cgra_fu_pkg::REG_COUNT)
  ) u_rf (
    .clk_i     (clk_i),
    .we_i      (s1_advance && alu_wr),
    .waddr_i   (s1_sb_q[AW-1:0]),
    .wdata_i   (alu_r),
    .re_i      (accept),
    .raddr_a_i (in_sa[AW-1:0]),
    .raddr_b_i (in_sel2[AW-1:0]),
    .rdata_a_o (rf_rdata_a),
    .rdata_b_o (rf_rdata_b)
  );

  // Operand stage control: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Operand stage payload. A write retiring on the same edge is forwarded
  // through hold_q, which then carries the written value.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= in_op;
      s1_sa_q    <= in_sa;
      s1_sb_q    <= in_sb;
      s1_sc_q    <= in_sc;
      s1_imm_q   <= s_axis_tdata[cgra_fu_pkg::OFS_IMM +: cgra_fu_pkg::IMM_W] &
                    cgra_fu_pkg::IMM_MASK;
      for (int n = 0; n < cgra_fu_pkg::NBR_NUM; n++) begin
        s1_nbr_q[n] <= s_axis_tdata[cgra_fu_pkg::OFS_NBR + n*DW +: DW];
      end
      s1_byp_a_q <= s1_advance && alu_wr && (s1_sb_q == in_sa);
      s1_byp_2_q <= s1_advance && alu_wr && (s1_sb_q == in_sel2);
      s1_vld_a_q <= rf_valid_q[in_sa[AW-1:0]];
      s1_vld_2_q <= rf_valid_q[in_sel2[AW-1:0]];
    end
  end

  // Register file valid bits: an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
    end else if (s1_advance && alu_wr) begin
      rf_valid_q[s1_sb_q[AW-1:0]] <= 1'b1;
    end
  end

  // Source availability check.
  function automatic logic src_ok(input logic [SW-1:0] sel, input logic rf_en,
                                  input logic [cgra_fu_pkg::NBR_NUM-1:0] nbr);
    logic ok;
    ok = 1'b0;
    if (sel < cgra_fu_pkg::SEL_SELF) begin
      ok = rf_en && (sel < cgra_fu_pkg::SEL_REG_LIM);
    end else if (sel == cgra_fu_pkg::SEL_SELF) begin
      ok = 1'b1;
    end else if (sel <= cgra_fu_pkg::SEL_NBR4) begin
      ok = nbr[2'(sel - cgra_fu_pkg::SEL_NBR1)];
    end
    return ok;
  endfunction

  // ALU stage: operand selection, operation and result flags.
  always_comb begin
    cgra_fu_pkg::op_e op;
    logic [SW-1:0]    sel2;
    logic [DW-1:0]    va;
    logic [DW-1:0]    v2;
    logic [DW-1:0]    opnd;
    logic [5:0]       sh;
    logic             immform;
    logic             regform;
    logic             reconf;
    logic [DW-1:0]    pp_ll;
    logic [31:0]      pp_cross;
    logic [DW-1:0]    sext_a;

    op      = cgra_fu_pkg::op_e'(s1_op_q);
    immform = op inside {cgra_fu_pkg::OP_ADDI, cgra_fu_pkg::OP_SUBI, cgra_fu_pkg::OP_SLLI,
                         cgra_fu_pkg::OP_SRLI, cgra_fu_pkg::OP_SRLWI, cgra_fu_pkg::OP_SRAI,
                         cgra_fu_pkg::OP_SRAWI, cgra_fu_pkg::OP_ORI, cgra_fu_pkg::OP_ANDI,
                         cgra_fu_pkg::OP_XORI};
    alu_nop = (op == cgra_fu_pkg::OP_NOP) || (s1_op_q > cgra_fu_pkg::OP_RECONF_IFNE);
    reconf  = (op == cgra_fu_pkg::OP_RECONF_IFEQ) || (op == cgra_fu_pkg::OP_RECONF_IFNE);
    regform = !immform && !alu_nop && (s1_op_q <= cgra_fu_pkg::OP_XORI);
    sel2    = reconf ? s1_sb_q : s1_sc_q;

    // A operand.
    if (s1_sa_q < cgra_fu_pkg::SEL_SELF) begin
      va = s1_byp_a_q ? hold_q : (s1_vld_a_q ? rf_rdata_a : '0);
    end else if (s1_sa_q == cgra_fu_pkg::SEL_SELF) begin
      va = hold_q;
    end else begin
      va = s1_nbr_q[2'(s1_sa_q - cgra_fu_pkg::SEL_NBR1)];
    end

    // Second operand (C or B).
    if (sel2 < cgra_fu_pkg::SEL_SELF) begin
      v2 = s1_byp_2_q ? hold_q : (s1_vld_2_q ? rf_rdata_b : '0);
    end else if (sel2 == cgra_fu_pkg::SEL_SELF) begin
      v2 = hold_q;
    end else begin
      v2 = s1_nbr_q[2'(sel2 - cgra_fu_pkg::SEL_NBR1)];
    end

    alu_abort = !alu_nop &&
                (!src_ok(s1_sa_q, rf_en_q, nbr_present_q) ||
                 ((regform || reconf) && !src_ok(sel2, rf_en_q, nbr_present_q)));

    opnd = immform ? DW'(s1_imm_q) : v2;
    sh   = opnd[5:0];

    // Low 64 bits of the product from three 32 by 32 partial products.
    pp_ll    = 64'(va[31:0]) * 64'(v2[31:0]);
    pp_cross = 32'(va[31:0] * v2[63:32]) + 32'(va[63:32] * v2[31:0]);
    sext_a   = {{32{va[31]}}, va[31:0]};

    alu_r   = hold_q;
    alu_hit = 1'b0;
    case (op)
      cgra_fu_pkg::OP_ADD, cgra_fu_pkg::OP_ADDI:   alu_r = va + opnd;
      cgra_fu_pkg::OP_SUB, cgra_fu_pkg::OP_SUBI:   alu_r = va - opnd;
      cgra_fu_pkg::OP_MUL: begin
        if (mult_en_q) begin
          alu_r = pp_ll + {pp_cross, 32'd0};
        end
      end
      cgra_fu_pkg::OP_SLL, cgra_fu_pkg::OP_SLLI:   alu_r = va << sh;
      cgra_fu_pkg::OP_SRL, cgra_fu_pkg::OP_SRLI:   alu_r = va >> sh;
      cgra_fu_pkg::OP_SRLW, cgra_fu_pkg::OP_SRLWI: alu_r = {32'd0, va[31:0]} >> sh;
      cgra_fu_pkg::OP_SRA, cgra_fu_pkg::OP_SRAI:   alu_r = DW'($signed(va) >>> sh);
      cgra_fu_pkg::OP_SRAW, cgra_fu_pkg::OP_SRAWI: alu_r = DW'($signed(sext_a) >>> sh);
      cgra_fu_pkg::OP_OR, cgra_fu_pkg::OP_ORI:     alu_r = va | opnd;
      cgra_fu_pkg::OP_AND, cgra_fu_pkg::OP_ANDI:   alu_r = va & opnd;
      cgra_fu_pkg::OP_XOR, cgra_fu_pkg::OP_XORI:   alu_r = va ^ opnd;
      cgra_fu_pkg::OP_CARRY:                       alu_r = va;
      cgra_fu_pkg::OP_RECONF_IFEQ:                 alu_hit = (va == v2);
      cgra_fu_pkg::OP_RECONF_IFNE:                 alu_hit = (va != v2);
      default: ;
    endcase

    // Nop and aborted items leave everything as it was.
    if (alu_nop || alu_abort) begin
      alu_r   = hold_q;
      alu_hit = 1'b0;
    end

    alu_wr     = !alu_nop && !alu_abort && (s1_op_q <= cgra_fu_pkg::OP_XORI) &&
                 rf_en_q && (s1_sb_q < cgra_fu_pkg::SEL_REG_LIM);
    alu_cycles = alu_hit ? ({1'b0, s1_imm_q} - cgra_fu_pkg::CYC_W'(1)) : '0;
  end

  // Latched unit output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else if (s1_advance) begin
      hold_q <= alu_r;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_value_q  <= alu_r;
      out_wr_q     <= alu_wr;
      out_dest_q   <= alu_wr ? cgra_fu_pkg::DEST_W'(s1_sb_q) : '0;
      out_hit_q    <= alu_hit;
      out_cycles_q <= alu_cycles;
      out_abort_q  <= alu_abort;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_abort_q, out_cycles_q, out_hit_q, out_dest_q,
                          out_wr_q, out_value_q};

endmodule

`default_nettype wire

### rtl/core/cgra_fu_checker.sv
// Port-level checker for the CGRA functional unit, bound to the top level.
// Depends on cgra_fu_pkg and the macros in cgra_functional_unit_alu_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "cgra_functional_unit_alu_assert.svh"

module cgra_fu_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              cfg_we_i,
  input wire logic [cgra_fu_pkg::CFG_AW-1:0]    cfg_addr_i,
  input wire logic [cgra_fu_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic [cgra_fu_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [cgra_fu_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic unused_cfg;
  assign unused_cfg = cfg_we_i ^ (^cfg_addr_i) ^ (^cfg_wdata_i) ^ (^s_axis_tdata);

  // A waiting result stays offered until it is taken.
  `CGRA_ASSERT_NXT(a_out_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // An aborted request neither writes a register nor triggers reconfiguration.
  `CGRA_ASSERT_IMP(a_abort_quiet, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[85], !m_axis_tdata[64] && !m_axis_tdata[71])

  // Without a register write the destination index reads zero.
  `CGRA_ASSERT_IMP(a_dest_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[64], m_axis_tdata[70:65] == 6'd0)

  // A result that triggers reconfiguration never writes a register.
  `CGRA_ASSERT_IMP(a_hit_no_write, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[71], !m_axis_tdata[64])

endmodule

bind cgra_functional_unit_alu cgra_fu_checker u_checker (.*);

`default_nettype wire

### dv/tb_top.sv
// Self-checking bench for the CGRA functional unit: directed table, then random requests.
// Uses cgra_fu_pkg for widths, operation codes, selector and register codes; needs the RTL.
`timescale 1ns / 1ps

module tb_top;
  import cgra_fu_pkg::*;

  // Codes that the package leaves unnamed.
  localparam logic [OP_W-1:0]  OP_RSVD_FIRST = 5'd25;
  localparam logic [OP_W-1:0]  OP_RSVD_LAST  = 5'd31;
  localparam logic [SEL_W-1:0] SEL_NBR2      = 7'd66;
  localparam logic [SEL_W-1:0] SEL_NBR3      = 7'd67;
  localparam logic [SEL_W-1:0] SEL_BAD       = 7'd127;

  localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONES  = 64'hffff_ffff_ffff_ffff;

  // Neighbour values for the directed rows, neighbour four first.
  localparam logic [3:0][63:0] NBR_SET0 = {64'd1, ONES, MIN64, MAX64};
  localparam logic [3:0][63:0] NBR_SET1 = {MAX64, 64'haaaa_aaaa_aaaa_aaaa,
                                           64'h5555_5555_5555_5555, 64'h0000_0000_8000_0000};

  localparam int HEAD_ROWS   = 8;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 135;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  // Request fields from the highest bit down, as packed on s_axis_tdata.
  typedef struct packed {
    logic [3:0][63:0]   nbr;
    logic [IMM_W-1:0]   imm;
    logic [SEL_W-1:0]   src_c;
    logic [SEL_W-1:0]   src_b;
    logic [SEL_W-1:0]   src_a;
    logic [OP_W-1:0]    req_type;
  } alu_req_t;

  // Result fields from the highest bit down, as packed on m_axis_tdata.
  typedef struct packed {
    logic               aborted;
    logic [CYC_W-1:0]   reconf_cycles;
    logic               reconf_hit;
    logic [DEST_W-1:0]  dest_index;
    logic               reg_written;
    logic [DATA_W-1:0]  out_value;
  } alu_res_t;

  typedef struct packed {
    alu_req_t req;
    logic     known;
    alu_res_t res;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_AW-1:0]    cfg_addr_i;
  logic [CFG_DW-1:0]    cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Shadow state of the unit.
  logic [63:0] rf_copy [REG_COUNT];
  logic [63:0] held_out;
  logic        mul_on;
  logic        rf_on;
  logic [3:0]  nbr_on;

  alu_res_t  results_due [$];
  stim_row_t stim_tab [$];
  idle_e     idle_mode = IDLE_NONE;
  int        mismatches = 0;

  cgra_functional_unit_alu dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Operand fetch; returns 0 when the source is not available.
  function automatic logic fetch_operand(input logic [SEL_W-1:0] sel, input alu_req_t q,
                                         output logic [63:0] v);
    v = '0;
    if (sel < SEL_REG_LIM) begin
      if (!rf_on) return 1'b0;
      v = rf_copy[sel[REG_AW-1:0]];
      return 1'b1;
    end
    if (sel == SEL_SELF) begin
      v = held_out;
      return 1'b1;
    end
    if (sel <= SEL_NBR4) begin
      if (!nbr_on[sel - SEL_NBR1]) return 1'b0;
      v = q.nbr[sel - SEL_NBR1];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Executes one request on the shadow state and returns the result it causes.
  function automatic alu_res_t alu_execute(input alu_req_t q);
    alu_res_t    o;
    logic [63:0] va, vb, vc, opnd, r;
    logic [5:0]  sh;
    logic        ok, immf, regf, reconf, hit;
    o = '0;
    r = held_out;
    hit = 1'b0;
    vb = '0;
    vc = '0;
    if (q.req_type == OP_NOP || q.req_type > OP_RECONF_IFNE) begin
      o.out_value = held_out;
      return o;
    end
    immf = q.req_type inside {OP_ADDI, OP_SUBI, OP_SLLI, OP_SRLI, OP_SRLWI, OP_SRAI,
                              OP_SRAWI, OP_ORI, OP_ANDI, OP_XORI};
    regf = !immf && q.req_type <= OP_XORI;
    reconf = q.req_type == OP_RECONF_IFEQ || q.req_type == OP_RECONF_IFNE;

    // A first, then C or B.
    ok = fetch_operand(q.src_a, q, va);
    if (ok && regf) ok = fetch_operand(q.src_c, q, vc);
    if (ok && reconf) ok = fetch_operand(q.src_b, q, vb);
    if (!ok) begin
      o.out_value = held_out;
      o.aborted = 1'b1;
      return o;
    end

    opnd = immf ? 64'(q.imm & IMM_MASK) : vc;
    sh = opnd[5:0];
    case (q.req_type)
      OP_ADD, OP_ADDI:   r = va + opnd;
      OP_SUB, OP_SUBI:   r = va - opnd;
      OP_MUL:            if (mul_on) r = va * vc;
      OP_SLL, OP_SLLI:   r = va << sh;
      OP_SRL, OP_SRLI:   r = va >> sh;
      OP_SRLW, OP_SRLWI: r = {32'd0, va[31:0]} >> sh;
      OP_SRA, OP_SRAI:   r = $signed(va) >>> sh;
      OP_SRAW, OP_SRAWI: r = $signed({{32{va[31]}}, va[31:0]}) >>> sh;
      OP_OR, OP_ORI:     r = va | opnd;
      OP_AND, OP_ANDI:   r = va & opnd;
      OP_XOR, OP_XORI:   r = va ^ opnd;
      OP_CARRY:          r = va;
      OP_RECONF_IFEQ:    hit = va == vb;
      OP_RECONF_IFNE:    hit = va != vb;
      default: ;
    endcase
    if (hit) o.reconf_cycles = {1'b0, q.imm & IMM_MASK} - 13'd1;

    held_out = r;
    // Only register and immediate forms write back.
    if (q.req_type <= OP_XORI && rf_on && q.src_b < SEL_REG_LIM) begin
      rf_copy[q.src_b[REG_AW-1:0]] = r;
      o.reg_written = 1'b1;
      o.dest_index = q.src_b[DEST_W-1:0];
    end
    o.out_value = r;
    o.reconf_hit = hit;
    return o;
  endfunction

  // One row of the directed table; the expected fields count only where known is set.
  function automatic stim_row_t row(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] a,
                                    input logic [SEL_W-1:0] b, input logic [SEL_W-1:0] c,
                                    input logic [IMM_W-1:0] imm, input int nset,
                                    input logic known = 1'b0, input logic [63:0] e_out = '0,
                                    input logic e_hit = 1'b0, input logic [CYC_W-1:0] e_cyc = '0,
                                    input logic e_ab = 1'b0);
    stim_row_t s;
    s = '0;
    s.req.req_type = op;
    s.req.src_a = a;
    s.req.src_b = b;
    s.req.src_c = c;
    s.req.imm = imm;
    s.req.nbr = (nset == 0) ? NBR_SET0 : NBR_SET1;
    s.known = known;
    s.res.out_value = e_out;
    s.res.reconf_hit = e_hit;
    s.res.reconf_cycles = e_cyc;
    s.res.aborted = e_ab;
    return s;
  endfunction

  // Operand selector, weighted towards a few registers so results feed later requests.
  function automatic logic [SEL_W-1:0] pick_sel();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return SEL_W'($urandom_range(0, 15));
    if (k < 55) return SEL_W'($urandom_range(0, 63));
    if (k < 70) return SEL_SELF;
    if (k < 95) return SEL_NBR1 + SEL_W'($urandom_range(0, 3));
    return SEL_W'($urandom_range(0, 127));
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t q;
    int       k;
    q = '0;
    q.req_type = ($urandom_range(0, 99) < 8) ? OP_W'($urandom_range(0, 31))
                                            : OP_W'($urandom_range(1, 24));
    q.src_a = pick_sel();
    q.src_c = pick_sel();
    if (q.req_type == OP_RECONF_IFEQ || q.req_type == OP_RECONF_IFNE) begin
      q.src_b = ($urandom_range(0, 2) == 0) ? q.src_a : pick_sel();
    end else begin
      k = $urandom_range(0, 9);
      if (k == 0)     q.src_b = SEL_W'($urandom_range(64, 127));
      else if (k < 3) q.src_b = SEL_W'($urandom_range(0, 63));
      else            q.src_b = SEL_W'($urandom_range(0, 15));
    end
    k = $urandom_range(0, 9);
    if (k < 5)      q.imm = IMM_W'($urandom_range(0, 4095));
    else if (k < 8) q.imm = IMM_W'($urandom_range(0, 70));
    else if (k == 8) q.imm = '1;
    else            q.imm = '0;
    // Neighbour values: wide random, small, extremes, or a copy for equal compares.
    for (int i = 0; i < NBR_NUM; i++) begin
      k = $urandom_range(0, 9);
      case (k)
        5, 6:    q.nbr[i] = 64'($urandom_range(0, 300));
        7:       q.nbr[i] = MIN64;
        8:       q.nbr[i] = MAX64;
        9:       q.nbr[i] = q.nbr[0];
        default: q.nbr[i] = {$urandom(), $urandom()};
      endcase
    end
    return q;
  endfunction

  function automatic logic sender_idles();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 67;
      IDLE_BOTH: return $urandom_range(0, 99) < 7;
      default:   return 1'b0;
    endcase
  endfunction

  // Presents one request, waits for its handshake, and files the result it should give.
  task automatic send_req(input alu_req_t q, input logic known, input alu_res_t typed);
    alu_res_t pred;
    logic     taken;
    while (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(q);
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    pred = alu_execute(q);
    results_due.push_back(known ? typed : pred);
  endtask

  // Stops requests and lets every pending result come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive edges.
  task automatic write_cfg(input logic mul, input logic rf, input logic [3:0] nbr);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_MULT_EN;
    cfg_wdata_i <= CFG_DW'(mul);
    @(posedge clk_i);
    cfg_addr_i  <= CFG_RF_EN;
    cfg_wdata_i <= CFG_DW'(rf);
    @(posedge clk_i);
    cfg_addr_i  <= CFG_NBR;
    cfg_wdata_i <= nbr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mul_on = mul;
    rf_on  = rf;
    nbr_on = nbr;
  endtask

  task automatic flag_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    mismatches++;
  endtask

  // Result side: ready per the idling phase.
  always @(posedge clk_i) begin
    case (idle_mode)
      IDLE_RECV: m_axis_tready <= $urandom_range(0, 99) >= 67;
      IDLE_BOTH: m_axis_tready <= $urandom_range(0, 99) >= 7;
      default:   m_axis_tready <= 1'b1;
    endcase
  end

  // Sampled mid-cycle, so the values are those taken at the next rising edge.
  always @(negedge clk_i) begin
    alu_res_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(alu_res_t)-1:0];
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (got.out_value !== want.out_value)
          flag_field("out_value", want.out_value, got.out_value);
        if (got.reg_written !== want.reg_written)
          flag_field("reg_written", want.reg_written, got.reg_written);
        if (got.dest_index !== want.dest_index)
          flag_field("dest_index", want.dest_index, got.dest_index);
        if (got.reconf_hit !== want.reconf_hit)
          flag_field("reconf_hit", want.reconf_hit, got.reconf_hit);
        if (got.reconf_cycles !== want.reconf_cycles)
          flag_field("reconf_cycles", want.reconf_cycles, got.reconf_cycles);
        if (got.aborted !== want.aborted)
          flag_field("aborted", want.aborted, got.aborted);
      end
    end
  end

  // Main sequence.
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = CFG_MULT_EN;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    for (int i = 0; i < REG_COUNT; i++) rf_copy[i] = '0;
    held_out = '0;
    mul_on   = 1'b0;
    rf_on    = 1'b0;
    nbr_on   = '0;

    // With reset settings only the unit's own output is reachable.
    stim_tab.push_back(row(OP_NOP, SEL_SELF, 7'd0, 7'd0, 12'd0, 0, 1'b1, 64'd0));
    stim_tab.push_back(row(OP_ADD, 7'd0, 7'd0, SEL_SELF, 12'd0, 0, 1'b1, 64'd0, 1'b0,
                           13'd0, 1'b1));
    stim_tab.push_back(row(OP_ADDI, SEL_SELF, 7'd0, 7'd0, 12'hfff, 0, 1'b1, 64'hfff));
    stim_tab.push_back(row(OP_SUB, SEL_SELF, 7'd1, SEL_BAD, 12'd0, 0, 1'b1, 64'hfff, 1'b0,
                           13'd0, 1'b1));
    stim_tab.push_back(row(OP_MUL, SEL_SELF, 7'd2, SEL_SELF, 12'd0, 0, 1'b1, 64'hfff));
    stim_tab.push_back(row(OP_RECONF_IFEQ, SEL_SELF, SEL_SELF, 7'd0, 12'd0, 0, 1'b1,
                           64'hfff, 1'b1, 13'h1fff));
    stim_tab.push_back(row(OP_RECONF_IFNE, SEL_SELF, 7'd0, 7'd0, 12'd5, 0, 1'b1, 64'hfff,
                           1'b0, 13'd0, 1'b1));
    stim_tab.push_back(row(OP_RSVD_LAST, SEL_BAD, SEL_BAD, SEL_BAD, 12'hfff, 0, 1'b1,
                           64'hfff));
    // Everything enabled: each operation, shift extremes, no-write and abort cases.
    stim_tab.push_back(row(OP_ADDI, SEL_SELF, 7'd0, 7'd0, 12'h800, 0));
    stim_tab.push_back(row(OP_SUB, SEL_NBR2, 7'd63, SEL_NBR1, 12'd0, 0));
    stim_tab.push_back(row(OP_MUL, SEL_NBR1, 7'd1, SEL_NBR1, 12'd0, 0));
    stim_tab.push_back(row(OP_SLL, SEL_NBR3, 7'd2, SEL_NBR4, 12'd0, 0));
    stim_tab.push_back(row(OP_SLLI, SEL_NBR1, 7'd3, 7'd0, 12'd63, 0));
    stim_tab.push_back(row(OP_SRL, 7'd63, SEL_BAD, SEL_NBR4, 12'd0, 0));
    stim_tab.push_back(row(OP_SRLI, SEL_NBR3, 7'd4, 7'd0, 12'hfff, 0));
    stim_tab.push_back(row(OP_SRLW, SEL_NBR1, 7'd5, 7'd0, 12'd0, 1));
    stim_tab.push_back(row(OP_SRLWI, SEL_NBR3, 7'd6, 7'd0, 12'd32, 0));
    stim_tab.push_back(row(OP_SRA, SEL_NBR2, 7'd7, SEL_NBR3, 12'd0, 0));
    stim_tab.push_back(row(OP_SRAI, SEL_NBR2, SEL_SELF, 7'd0, 12'd1, 0));
    stim_tab.push_back(row(OP_SRAW, SEL_NBR1, 7'd8, SEL_NBR4, 12'd0, 1));
    stim_tab.push_back(row(OP_SRAWI, SEL_NBR1, 7'd9, 7'd0, 12'd31, 1));
    stim_tab.push_back(row(OP_OR, 7'd0, 7'd10, 7'd63, 12'd0, 0));
    stim_tab.push_back(row(OP_ORI, SEL_NBR2, 7'd11, 7'd0, 12'haaa, 1));
    stim_tab.push_back(row(OP_AND, SEL_NBR2, 7'd12, SEL_NBR3, 12'd0, 1));
    stim_tab.push_back(row(OP_ANDI, SEL_NBR3, 7'd13, 7'd0, 12'h555, 0));
    stim_tab.push_back(row(OP_XOR, SEL_NBR2, 7'd14, SEL_NBR3, 12'd0, 1));
    stim_tab.push_back(row(OP_XORI, 7'd0, 7'd15, 7'd0, 12'hfff, 0));
    stim_tab.push_back(row(OP_SUBI, 7'd0, 7'd16, 7'd0, 12'd1, 0));
    stim_tab.push_back(row(OP_CARRY, SEL_NBR1, 7'd17, 7'd0, 12'd0, 1));
    stim_tab.push_back(row(OP_RECONF_IFEQ, 7'd0, 7'd0, 7'd0, 12'd1, 0));
    stim_tab.push_back(row(OP_RECONF_IFNE, SEL_NBR1, SEL_NBR2, 7'd0, 12'hfff, 0));
    stim_tab.push_back(row(OP_ADD, 7'd0, 7'd18, SEL_BAD, 12'd0, 0));
    stim_tab.push_back(row(OP_RSVD_FIRST, 7'd0, 7'd0, 7'd0, 12'd0, 0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (stim_tab[i]) begin
      if (i == HEAD_ROWS) begin
        settle();
        write_cfg(1'b1, 1'b1, 4'hf);
        idle_mode = IDLE_BOTH;
      end
      send_req(stim_tab[i].req, stim_tab[i].known, stim_tab[i].res);
    end

    // Random phases, each with its own settings and idling pattern.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        1:       write_cfg(1'b0, 1'b1, 4'ha);
        2:       write_cfg(1'b1, 1'b0, 4'h5);
        4, 5:    write_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           4'($urandom_range(0, 15)));
        6:       write_cfg(1'b0, 1'b0, 4'h0);
        default: write_cfg(1'b1, 1'b1, 4'hf);
      endcase
      idle_mode = idle_e'(ph % 4);
      repeat (PHASE_ITEMS) send_req(rand_req(), 1'b0, '0);
    end

    settle();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
